/* src/tbe_pkg.sv */
package tbe_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int POLE_STAGES = 4;
    localparam int DELAY_TAPS  = 3;
    localparam int POLE_BITS   = SAMPLE_BITS + 16;
    localparam int COEF_BITS   = 18;
    localparam int GAIN_BITS   = 16;
    localparam int CFG_BITS    = 18;
    localparam int IDX_BITS    = 3;
    localparam int DIGIT       = 4;
    localparam logic [COEF_BITS-1:0] COEF_MAX = 18'd131072;

    localparam logic [IDX_BITS-1:0] REG_LOW_GAIN  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_MID_GAIN  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_HIGH_GAIN = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_LOW_COEF  = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_HIGH_COEF = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_STEREO    = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } out_item_t;

    // magnitude of a signed value, two bits wider than a pole value
    localparam int MAG_BITS = POLE_BITS + 2;

    typedef struct packed {
        logic                start;
        logic [MAG_BITS-1:0] mag;
        logic [COEF_BITS-1:0] coef;
    } mul_req_t;

endpackage

/* src/tbe_mul.sv */
// Digit-serial magnitude multiplier: round(mag * coef / 2^16), halves up on
// magnitude. Consumes one 4-bit digit of mag per cycle, LSB first.
module tbe_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbe_pkg::mul_req_t    req,
    output logic                 done,
    output logic [tbe_pkg::MAG_BITS+tbe_pkg::COEF_BITS-17:0] prod
);
    import tbe_pkg::*;

    localparam int STEPS = (MAG_BITS + DIGIT - 1) / DIGIT;
    localparam int SH_BITS = STEPS * DIGIT;
    localparam int ACC_BITS = SH_BITS + COEF_BITS;
    localparam int CNT_BITS = $clog2(STEPS + 1);

    logic [SH_BITS-1:0]   sh_reg, sh_next;
    logic [ACC_BITS-1:0]  acc_reg, acc_next;
    logic [COEF_BITS-1:0] coef_reg, coef_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [COEF_BITS+DIGIT-1:0] pp;
    logic [ACC_BITS-1:0]  sum;

    // accumulator holds the product aligned to the top; shift right per digit
    assign pp  = (COEF_BITS+DIGIT)'(coef_reg) * (COEF_BITS+DIGIT)'(sh_reg[DIGIT-1:0]);
    assign sum = (acc_reg >> DIGIT) + {pp, {(SH_BITS-DIGIT){1'b0}}};

    always_comb
    begin
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        coef_next = coef_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            sh_next   = SH_BITS'(req.mag);
            coef_next = req.coef;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum;
            sh_next  = sh_reg >> DIGIT;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(STEPS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
        coef_reg <= coef_next;
    end

    logic [ACC_BITS-16:0] rnd;
    assign rnd  = acc_reg[ACC_BITS-1:15] + 1'b1;
    assign done = busy_reg == 1'b0 && cnt_reg == CNT_BITS'(STEPS);
    assign prod = rnd[MAG_BITS+COEF_BITS-16:1];
endmodule

/* src/three_band_equalizer.sv */
// Three-band equalizer, one stereo frame per request; in mono mode only the left channel is computed.
// Each multiply runs through start (ST_MUL), the 11-digit serial multiplier (ST_WAIT) and advance (ST_NEXT).
// A channel needs 11 multiplies (8 poles, 3 gains).
// A new request is taken only once the previous frame has been moved to the output
// register; a result may wait in the output.
// Reset clears pole state, delay lines and registers to defaults at once.
module three_band_equalizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  tbe_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tbe_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [tbe_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [tbe_pkg::CFG_BITS-1:0]  cfg_data
);
    import tbe_pkg::*;

    localparam int PB = POLE_BITS;
    localparam int WB = PB + 4;
    localparam int PR = MAG_BITS + COEF_BITS - 16;
    localparam int SB = $clog2(2 * POLE_STAGES + 4);
    localparam int KB = $clog2(POLE_STAGES);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_WAIT = 5'b00100,
        ST_NEXT = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    logic [GAIN_BITS-1:0] low_gain_reg, mid_gain_reg, high_gain_reg;
    logic [COEF_BITS-1:0] low_coef_reg, high_coef_reg, c18;
    logic                 stereo_reg;

    logic signed [PB-1:0] low_poles_reg  [2][POLE_STAGES];
    logic signed [PB-1:0] high_poles_reg [2][POLE_STAGES];
    logic signed [SAMPLE_BITS-1:0] hist_reg [2][DELAY_TAPS];

    state_t state_reg;
    logic   ch_reg;
    logic [SB-1:0] step_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg [2];
    logic signed [SAMPLE_BITS-1:0] res_reg [2];
    logic signed [WB-1:0] acc_reg;
    logic neg_reg;
    logic out_valid_reg;
    out_item_t out_data_reg;
    logic out_load;

    mul_req_t req;
    logic     mdone;
    logic [PR-1:0] prod;

    tbe_mul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .done(mdone), .prod(prod));

    assign c18 = (cfg_data > COEF_MAX) ? COEF_MAX : cfg_data;

    // step: 0..P-1 low poles, P..2P-1 high poles, then low, mid, high gains
    logic signed [WB-1:0] opnd, band_lo, band_hi, band_mid, dly;
    logic [COEF_BITS-1:0] opc;
    logic is_pole, is_low;
    logic [KB-1:0] k;
    logic signed [WB-1:0] prev, cur, sprod, upd, sat_upd;
    logic signed [WB-1:0] lim;

    assign dly = WB'(hist_reg[ch_reg][DELAY_TAPS-1]) <<< 16;
    assign band_lo  = WB'(low_poles_reg[ch_reg][POLE_STAGES-1]);
    assign band_hi  = dly - WB'(high_poles_reg[ch_reg][POLE_STAGES-1]);
    assign band_mid = WB'(high_poles_reg[ch_reg][POLE_STAGES-1]) - band_lo;
    assign is_pole  = step_reg < SB'(2 * POLE_STAGES);
    assign is_low   = step_reg < SB'(POLE_STAGES);
    assign k = is_low ? step_reg[KB-1:0]
                      : KB'(step_reg - SB'(POLE_STAGES));

    always_comb
    begin
        cur  = is_low ? WB'(low_poles_reg[ch_reg][k]) : WB'(high_poles_reg[ch_reg][k]);
        if (k == 0)
            prev = WB'(x_reg[ch_reg]) <<< 16;
        else
            prev = is_low ? WB'(low_poles_reg[ch_reg][k - 1'b1])
                          : WB'(high_poles_reg[ch_reg][k - 1'b1]);
        if (is_pole)
        begin
            opnd = prev - cur;
            opc  = is_low ? low_coef_reg : high_coef_reg;
        end
        else if (step_reg == SB'(2 * POLE_STAGES))
        begin
            opnd = band_lo;
            opc  = COEF_BITS'(low_gain_reg);
        end
        else if (step_reg == SB'(2 * POLE_STAGES + 1))
        begin
            opnd = band_mid;
            opc  = COEF_BITS'(mid_gain_reg);
        end
        else
        begin
            opnd = band_hi;
            opc  = COEF_BITS'(high_gain_reg);
        end
    end

    assign req.start = (state_reg == ST_MUL);
    assign req.mag   = MAG_BITS'(opnd[WB-1] ? -opnd : opnd);
    assign req.coef  = opc;

    assign sprod = neg_reg ? -WB'(prod) : WB'(prod);
    assign upd   = cur + sprod;
    assign lim   = WB'(1) <<< (PB - 1);
    assign sat_upd = (upd > lim - 1) ? lim - 1 : (upd < -lim) ? -lim : upd;

    // final rounding of the gain sum
    logic signed [WB-1:0] amag, rs, slim;
    logic signed [SAMPLE_BITS-1:0] y;
    assign amag = acc_reg[WB-1] ? -acc_reg : acc_reg;
    assign rs   = (amag + WB'(8192)) >>> 14;
    assign slim = WB'(1) <<< (SAMPLE_BITS - 1);
    always_comb
    begin
        logic signed [WB-1:0] v;
        v = acc_reg[WB-1] ? -rs : rs;
        if (v > slim - 1)
            y = SAMPLE_BITS'(slim - 1);
        else if (v < -slim)
            y = SAMPLE_BITS'(-slim);
        else
            y = SAMPLE_BITS'(v);
    end

    // move the finished frame out once the output register is free
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            low_gain_reg  <= 16'd16384;
            mid_gain_reg  <= 16'd16384;
            high_gain_reg <= 16'd16384;
            low_coef_reg  <= 18'd8214;
            high_coef_reg <= 18'd45707;
            stereo_reg    <= 1'b1;
            for (int c = 0; c < 2; c++)
            begin
                for (int i = 0; i < POLE_STAGES; i++)
                begin
                    low_poles_reg[c][i]  <= '0;
                    high_poles_reg[c][i] <= '0;
                end
                for (int i = 0; i < DELAY_TAPS; i++)
                    hist_reg[c][i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LOW_GAIN:  low_gain_reg  <= cfg_data[GAIN_BITS-1:0];
                    REG_MID_GAIN:  mid_gain_reg  <= cfg_data[GAIN_BITS-1:0];
                    REG_HIGH_GAIN: high_gain_reg <= cfg_data[GAIN_BITS-1:0];
                    REG_LOW_COEF:  low_coef_reg  <= c18;
                    REG_HIGH_COEF: high_coef_reg <= c18;
                    REG_STEREO:    stereo_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
            unique case (state_reg)
                ST_IDLE:
                    if (in_valid && !in_stall)
                    begin
                        ch_reg    <= 1'b0;
                        step_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                ST_MUL:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                    if (mdone)
                    begin
                        if (is_pole)
                        begin
                            if (is_low)
                                low_poles_reg[ch_reg][k] <= PB'(sat_upd);
                            else
                                high_poles_reg[ch_reg][k] <= PB'(sat_upd);
                        end
                        state_reg <= ST_NEXT;
                    end
                ST_NEXT:
                    if (step_reg == SB'(2 * POLE_STAGES + 2))
                    begin
                        res_reg[ch_reg] <= y;
                        for (int i = DELAY_TAPS - 1; i > 0; i--)
                            hist_reg[ch_reg][i] <= hist_reg[ch_reg][i-1];
                        hist_reg[ch_reg][0] <= x_reg[ch_reg];
                        step_reg <= '0;
                        if (!ch_reg && stereo_reg)
                        begin
                            ch_reg    <= 1'b1;
                            state_reg <= ST_MUL;
                        end
                        else
                            state_reg <= ST_OUT;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                ST_OUT:
                    if (out_load)
                        state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && !in_stall)
        begin
            x_reg[0] <= in_data.left_sample;
            x_reg[1] <= in_data.right_sample;
        end
        if (state_reg == ST_MUL)
        begin
            neg_reg <= opnd[WB-1];
            if (step_reg == '0)
                acc_reg <= '0;
        end
        if (state_reg == ST_WAIT && mdone && !is_pole)
            acc_reg <= acc_reg + sprod;
        if (out_load)
        begin
            out_data_reg.left_out  <= res_reg[0];
            out_data_reg.right_out <= stereo_reg ? res_reg[1] : res_reg[0];
        end
    end

    a_no_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !(out_valid_reg && $rose(out_valid_reg) && state_reg == ST_MUL))
        else $error("result raised during computation");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result without finished frame");
    a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("request taken while busy");
endmodule
